// ----- design/gak_pkg.sv -----
package gak_pkg;

    localparam int GAK_MAX_DIMS = 16;

    // configuration register indexes
    localparam logic [1:0] CFG_ACTIVE_DIMS = 2'd0;
    localparam logic [1:0] CFG_TAIL_ENABLE = 2'd1;
    localparam logic [1:0] CFG_NUGGET      = 2'd2;

    // 0.5*log2(e) in Q0.16
    localparam logic [15:0] LOG2E_HALF = 16'd47274;

    localparam logic signed [49:0] ACC_MAX = 50'sd140737488355327;
    localparam logic signed [49:0] ACC_MIN = -50'sd140737488355328;
    localparam logic signed [49:0] OUT_MAX = 50'sd549755813887;
    localparam logic signed [49:0] OUT_MIN = -50'sd549755813888;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQ,
        S_FIN_RD,
        S_EXP1,
        S_EXP2,
        S_MUL,
        S_ACC,
        S_OUT
    } t_state;

    // round(65536 * 2^(-j/16))
    function automatic logic [16:0] pow2_frac(input logic [4:0] j);
        logic [16:0] v;
        case (j)
            5'd0:    v = 17'd65536;
            5'd1:    v = 17'd62757;
            5'd2:    v = 17'd60097;
            5'd3:    v = 17'd57549;
            5'd4:    v = 17'd55109;
            5'd5:    v = 17'd52773;
            5'd6:    v = 17'd50535;
            5'd7:    v = 17'd48393;
            5'd8:    v = 17'd46341;
            5'd9:    v = 17'd44376;
            5'd10:   v = 17'd42495;
            5'd11:   v = 17'd40693;
            5'd12:   v = 17'd38968;
            5'd13:   v = 17'd37316;
            5'd14:   v = 17'd35734;
            5'd15:   v = 17'd34219;
            5'd16:   v = 17'd32768;
            default: v = 17'd32768;
        endcase
        return v;
    endfunction

endpackage

// ----- design/gp_additive_rbf_kernel_core.sv -----
// Additive squared-exponential covariance core.
// A pooled or ignored element passes through S_SQ alone, a tail element also through S_EXP1,
// S_EXP2, S_MUL and S_ACC; after the last element the pooled term takes S_FIN_RD to S_ACC and
// the result registers in S_OUT, which waits while the result channel stalls.
// The input stalls until an element is through, as all share the single exp/multiply path.
// Reset (synchronous, active low) clears configuration, sums, weight valid bits and output
// valid; every table entry then reads as zero until written.
module gp_additive_rbf_kernel_core
    import gak_pkg::*;
#(
    parameter int MAX_DIMS = GAK_MAX_DIMS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // element / weight channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_op,
    input  logic signed [15:0] i_coord_a,
    input  logic signed [15:0] i_coord_b,
    input  logic               i_last,
    input  logic               i_add_nugget,
    input  logic [4:0]         i_weight_index,
    input  logic signed [31:0] i_weight_value,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [39:0] o_kernel_value,
    // configuration write channel
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);
    localparam int DEPTH = MAX_DIMS + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = $clog2(MAX_DIMS + 1);

    // control state
    t_state                r_state, n_state;
    logic [PW-1:0]         r_cnt, n_cnt;
    logic [31:0]           r_pool, n_pool;
    logic signed [47:0]    r_acc, n_acc;
    logic                  r_fin, n_fin;
    logic [DEPTH-1:0]      r_wvalid;
    logic                  r_rdvalid;
    logic                  r_out_valid, n_out_valid;
    logic [4:0]            r_active;
    logic                  r_tail;
    logic [31:0]           r_nug;

    // payload
    logic signed [15:0]    r_a, r_b;
    logic                  r_last, r_addnug;
    logic [31:0]           r_s, n_s;
    logic [31:0]           r_w, n_w;
    logic signed [33:0]    r_term, n_term;
    logic signed [39:0]    r_out, n_out;

    logic                  in_acc;
    logic                  we;
    logic [7:0]            widx8;
    logic [AW-1:0]         raddr;
    logic [31:0]           rdata;
    logic [16:0]           e;

    logic signed [16:0]    d;
    logic [16:0]           ad;
    logic [33:0]           sq_full;
    logic [31:0]           sq;
    logic [32:0]           pool_sum;
    logic [7:0]            p8, a8, wi8;
    logic                  in_range, pooled_sel, tail_sel;
    logic [31:0]           mag;
    logic [48:0]           wprod;
    logic [32:0]           pmag;
    logic signed [49:0]    acc_sum, fin_sum;

    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_kernel_value = r_out;

    // weight table writes land only while idle, so no read can overlap them
    assign widx8 = 8'(i_weight_index);
    assign we    = in_acc && i_op && (widx8 <= 8'(MAX_DIMS));

    gak_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_wtab (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (widx8[AW-1:0]),
        .i_wdata (i_weight_value),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    gak_exp u_exp (
        .i_clk (i_clk),
        .i_s   (r_s),
        .o_e   (e)
    );

    // configuration and weight valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= '0;
            r_tail    <= 1'b0;
            r_nug     <= '0;
            r_wvalid  <= '0;
            r_rdvalid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_ACTIVE_DIMS: r_active <= i_cfg_data[4:0];
                    CFG_TAIL_ENABLE: r_tail   <= i_cfg_data[0];
                    CFG_NUGGET:      r_nug    <= i_cfg_data;
                    default:         ;
                endcase
            end
            if (we) begin
                r_wvalid[widx8[AW-1:0]] <= 1'b1;
            end
            r_rdvalid <= r_wvalid[raddr];
        end
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_pool      <= '0;
            r_acc       <= '0;
            r_fin       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_pool      <= n_pool;
            r_acc       <= n_acc;
            r_fin       <= n_fin;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a      <= i_coord_a;
            r_b      <= i_coord_b;
            r_last   <= i_last;
            r_addnug <= i_add_nugget;
        end
        r_s    <= n_s;
        r_w    <= n_w;
        r_term <= n_term;
        r_out  <= n_out;
    end

    // squared difference, truncated to Q16.16
    always_comb begin
        d        = 17'(r_a) - 17'(r_b);
        ad       = d[16] ? 17'(-d) : 17'(d);
        sq_full  = 34'(ad) * 34'(ad);
        sq       = sq_full[33:8] == 26'd0 ? 32'd0 : 32'(sq_full[33:8]);
        pool_sum = 33'(r_pool) + 33'(sq);
        p8       = 8'(r_cnt);
        a8       = 8'(r_active);
        wi8      = p8 - a8 + 8'd1;
        in_range = p8 < 8'(MAX_DIMS);
        pooled_sel = p8 < a8;
        tail_sel = !pooled_sel && r_tail && (wi8 <= 8'(MAX_DIMS));
    end

    // signed weight times Q1.16 exponential, truncated toward zero
    always_comb begin
        mag   = r_w[31] ? 32'(-r_w) : r_w;
        wprod = 49'(mag) * 49'(e);
        pmag  = wprod[48:16];
        n_term = r_w[31] ? -34'(pmag) : 34'(pmag);
    end

    always_comb begin
        acc_sum = 50'(r_acc) + 50'(r_term);
        fin_sum = 50'(r_acc)
                + ((r_active != 5'd0) ? 50'(r_term) : 50'sd0)
                + (r_addnug ? $signed(50'(r_nug)) : 50'sd0);
    end

    // next state and datapath control
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_pool      = r_pool;
        n_acc       = r_acc;
        n_fin       = r_fin;
        n_s         = r_s;
        n_w         = r_w;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        raddr       = '0;

        case (r_state)
            S_IDLE: begin
                if (in_acc && !i_op) begin
                    n_state = S_SQ;
                end
            end
            S_SQ: begin
                raddr = wi8[AW-1:0];
                n_fin = 1'b0;
                n_s   = sq;
                if (in_range) begin
                    n_cnt = r_cnt + PW'(1);
                    if (pooled_sel) begin
                        n_pool = pool_sum[32] ? 32'hFFFF_FFFF : pool_sum[31:0];
                    end
                end
                if (in_range && tail_sel) begin
                    n_state = S_EXP1;
                end else if (r_last) begin
                    n_state = S_FIN_RD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_FIN_RD: begin
                raddr   = '0;
                n_fin   = 1'b1;
                n_s     = r_pool;
                n_state = S_EXP1;
            end
            S_EXP1: begin
                // unwritten entries read as zero
                n_w     = r_rdvalid ? rdata : 32'd0;
                n_state = S_EXP2;
            end
            S_EXP2: begin
                n_state = S_MUL;
            end
            S_MUL: begin
                n_state = S_ACC;
            end
            S_ACC: begin
                if (r_fin) begin
                    n_state = S_OUT;
                end else begin
                    if (acc_sum > ACC_MAX) begin
                        n_acc = ACC_MAX[47:0];
                    end else if (acc_sum < ACC_MIN) begin
                        n_acc = ACC_MIN[47:0];
                    end else begin
                        n_acc = acc_sum[47:0];
                    end
                    n_state = r_last ? S_FIN_RD : S_IDLE;
                end
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    if (fin_sum > OUT_MAX) begin
                        n_out = OUT_MAX[39:0];
                    end else if (fin_sum < OUT_MIN) begin
                        n_out = OUT_MIN[39:0];
                    end else begin
                        n_out = fin_sum[39:0];
                    end
                    n_out_valid = 1'b1;
                    n_cnt   = '0;
                    n_pool  = '0;
                    n_acc   = '0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end
endmodule

// ----- design/gak_ram.sv -----
module gak_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 17
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- design/gak_exp.sv -----
// exp(-0.5*s), two register stages: scale to log2 domain, then interpolate and shift
module gak_exp
    import gak_pkg::*;
(
    input  logic        i_clk,
    input  logic [31:0] i_s,
    output logic [16:0] o_e
);
    logic [47:0] t_full;
    logic [31:0] r_t;
    logic [15:0] k;
    logic [4:0]  i_idx;
    logic [11:0] f;
    logic [16:0] t_lo;
    logic [16:0] t_hi;
    logic [16:0] diff;
    logic [28:0] dprod;
    logic [16:0] m;
    logic [16:0] n_e;
    logic [16:0] r_e;

    assign t_full = 48'(i_s) * 48'(LOG2E_HALF);

    always_ff @(posedge i_clk) begin
        r_t <= t_full[47:16];
        r_e <= n_e;
    end

    always_comb begin
        k     = r_t[31:16];
        i_idx = {1'b0, r_t[15:12]};
        f     = r_t[11:0];
        t_lo  = pow2_frac(i_idx);
        t_hi  = pow2_frac(i_idx + 5'd1);
        diff  = t_lo - t_hi;
        dprod = 29'(diff) * 29'(f);
        m     = t_lo - 17'(dprod >> 12);
        if (k >= 16'd17) begin
            n_e = '0;
        end else begin
            n_e = m >> k[4:0];
        end
    end

    assign o_e = r_e;
endmodule

// ----- design/gak_checker.sv -----
module gak_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               i_op,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic signed [39:0] o_kernel_value,
    input logic               o_cfg_ready
);
    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_kernel_value))
        else $error("result changed while stalled");

    // an accepted element transaction moves the sequencer out of S_IDLE, so the input stalls
    a_elem_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && !i_op |=> o_in_stall)
        else $error("element not processed");

    // weight writes never hold the input
    a_wr_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_op |=> !o_in_stall)
        else $error("weight write stalled input");

    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_cfg_ready)
        else $error("output valid after reset");
endmodule

bind gp_additive_rbf_kernel_core gak_checker u_gak_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .i_op           (i_op),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_kernel_value (o_kernel_value),
    .o_cfg_ready    (o_cfg_ready)
);
